// File: rtl/spline_interp_weight_generator_defines.svh
// Assertion macros shared by the RTL.
// Both expect clk_i and rst_ni in scope.
`ifndef SPLINE_INTERP_WEIGHT_GENERATOR_DEFINES_SVH
`define SPLINE_INTERP_WEIGHT_GENERATOR_DEFINES_SVH

// Same-cycle implication.
`define SWG_ASSERT_IMP(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |-> (post)) \
    else $error(msg);

// Next-cycle implication.
`define SWG_ASSERT_NXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error(msg);

`endif

// File: rtl/swg_pkg.sv
`default_nettype none

package swg_pkg;

  localparam int LANES = 6;
  localparam int ACC_W = 46;

  typedef enum logic [2:0] {
    K_HAAR     = 3'd0,
    K_BSPLINE2 = 3'd1,
    K_BSPLINE3 = 3'd2,
    K_OMOMS3   = 3'd3,
    K_BSPLINE4 = 3'd4,
    K_BSPLINE5 = 3'd5
  } swg_kind_e;

  // odd factor of the kernel denominator
  typedef enum logic [1:0] {
    DIV_1  = 2'd0,
    DIV_3  = 2'd1,
    DIV_15 = 2'd2,
    DIV_21 = 2'd3
  } swg_div_e;

  localparam logic [1:0] REG_KIND  = 2'd0;
  localparam logic [1:0] REG_ORDER = 2'd1;
  localparam logic [2:0] KIND_RESET  = 3'd2;
  localparam logic [2:0] ORDER_RESET = 3'd0;

  typedef struct packed {
    logic       shifted;
    logic [1:0] half;
    logic [2:0] support;
    logic [1:0] max_order;
    logic       ok;
    logic [6:0] base;
    logic [2:0] dshift;
    swg_div_e   dcode;
  } swg_kinfo_t;

  // item traveling through the Horner stages
  typedef struct packed {
    logic signed [16:0]          start;
    logic                        err;
    swg_div_e                    dcode;
    logic [2:0]                  dshift;
    logic [LANES-1:0]            mask;
    logic signed [16:0]          u;
    logic [LANES-1:0][6:0]       rows;
    logic [LANES-1:0][ACC_W-1:0] acc;
  } swg_item_t;

  typedef struct packed {
    logic signed [16:0]               start;
    logic                             err;
    logic [LANES-1:0][23:0]           w;
  } swg_res_t;

  // Polynomial rows, coefficients of x^0 .. x^5.
  localparam int POLY [82][6] = '{
    '{1,0,0,0,0,0},
    '{1,-4,4,0,0,0}, '{6,0,-8,0,0,0}, '{1,4,4,0,0,0},
    '{-4,8,0,0,0,0}, '{0,-16,0,0,0,0}, '{4,8,0,0,0,0},
    '{8,0,0,0,0,0}, '{-16,0,0,0,0,0}, '{8,0,0,0,0,0},
    '{1,-3,3,-1,0,0}, '{4,0,-6,3,0,0}, '{1,3,3,-3,0,0}, '{0,0,0,1,0,0},
    '{-3,6,-3,0,0,0}, '{0,-12,9,0,0,0}, '{3,6,-9,0,0,0}, '{0,0,3,0,0,0},
    '{6,-6,0,0,0,0}, '{-12,18,0,0,0,0}, '{6,-18,0,0,0,0}, '{0,6,0,0,0,0},
    '{-6,0,0,0,0,0}, '{18,0,0,0,0,0}, '{-18,0,0,0,0,0}, '{6,0,0,0,0,0},
    '{8,-22,21,-7,0,0}, '{26,3,-42,21,0,0}, '{8,18,21,-21,0,0}, '{0,1,0,7,0,0},
    '{-22,42,-21,0,0,0}, '{3,-84,63,0,0,0}, '{18,42,-63,0,0,0}, '{1,0,21,0,0,0},
    '{42,-42,0,0,0,0}, '{-84,126,0,0,0,0}, '{42,-126,0,0,0,0}, '{0,42,0,0,0,0},
    '{1,-8,24,-32,16,0}, '{76,-176,96,64,-64,0}, '{230,0,-240,0,96,0},
    '{76,176,96,-64,-64,0}, '{1,8,24,32,16,0},
    '{-8,48,-96,64,0,0}, '{-176,192,192,-256,0,0}, '{0,-480,0,384,0,0},
    '{176,192,-192,-256,0,0}, '{8,48,96,64,0,0},
    '{48,-192,192,0,0,0}, '{192,384,-768,0,0,0}, '{-480,0,1152,0,0,0},
    '{192,-384,-768,0,0,0}, '{48,192,192,0,0,0},
    '{-192,384,0,0,0,0}, '{384,-1536,0,0,0,0}, '{0,2304,0,0,0,0},
    '{-384,-1536,0,0,0,0}, '{192,384,0,0,0,0},
    '{1,-5,10,-10,5,-1}, '{26,-50,20,20,-20,5}, '{66,0,-60,0,30,-10},
    '{26,50,20,-20,-20,10}, '{1,5,10,10,5,-5}, '{0,0,0,0,0,1},
    '{-5,20,-30,20,-5,0}, '{-50,40,60,-80,25,0}, '{0,-120,0,120,-50,0},
    '{50,40,-60,-80,50,0}, '{5,20,30,20,-25,0}, '{0,0,0,0,5,0},
    '{20,-60,60,-20,0,0}, '{40,120,-240,100,0,0}, '{-120,0,360,-200,0,0},
    '{40,-120,-240,200,0,0}, '{20,60,60,-100,0,0}, '{0,0,0,20,0,0},
    '{-60,120,-60,0,0,0}, '{120,-480,300,0,0,0}, '{0,720,-600,0,0,0},
    '{-120,-480,600,0,0,0}, '{60,120,-300,0,0,0}, '{0,0,60,0,0,0}
  };

  function automatic logic signed [12:0] coef(input logic [6:0] row, input logic [2:0] k);
    logic signed [12:0] c;
    c = '0;
    if (row < 7'd82 && k < 3'd6) begin
      c = 13'(POLY[row][k]);
    end
    return c;
  endfunction

  // coefficient placed at Q32
  function automatic logic [ACC_W-1:0] coef_q32(input logic signed [12:0] c);
    return {c[12], c, 32'd0};
  endfunction

  function automatic swg_kinfo_t kinfo(input logic [2:0] kind);
    swg_kinfo_t k;
    case (kind)
      K_HAAR:     k = '{1'b1, 2'd0, 3'd1, 2'd0, 1'b1, 7'd0,  3'd0, DIV_1};
      K_BSPLINE2: k = '{1'b1, 2'd1, 3'd3, 2'd2, 1'b1, 7'd1,  3'd3, DIV_1};
      K_BSPLINE3: k = '{1'b0, 2'd1, 3'd4, 2'd3, 1'b1, 7'd10, 3'd1, DIV_3};
      K_OMOMS3:   k = '{1'b0, 2'd1, 3'd4, 2'd2, 1'b1, 7'd26, 3'd1, DIV_21};
      K_BSPLINE4: k = '{1'b1, 2'd2, 3'd5, 2'd3, 1'b1, 7'd38, 3'd7, DIV_3};
      K_BSPLINE5: k = '{1'b0, 2'd2, 3'd6, 2'd3, 1'b1, 7'd58, 3'd3, DIV_15};
      default:    k = '{1'b0, 2'd0, 3'd0, 2'd0, 1'b0, 7'd0,  3'd0, DIV_1};
    endcase
    return k;
  endfunction

  function automatic logic [4:0] div_b(input swg_div_e d);
    logic [4:0] b;
    case (d)
      DIV_3:   b = 5'd3;
      DIV_15:  b = 5'd15;
      DIV_21:  b = 5'd21;
      default: b = 5'd1;
    endcase
    return b;
  endfunction

  // floor(2^32 / b)
  function automatic logic [31:0] div_r(input swg_div_e d);
    logic [31:0] r;
    case (d)
      DIV_3:   r = 32'd1431655765;
      DIV_15:  r = 32'd286331153;
      DIV_21:  r = 32'd204522252;
      default: r = 32'd0;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

// File: rtl/swg_intf.sv
`default_nettype none

interface swg_pos_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] position;
  modport source (output valid, output position, input ready);
  modport sink   (input valid, input position, output ready);
endinterface

interface swg_res_if;
  logic               valid;
  logic               ready;
  logic signed [16:0] start_index;
  logic signed [23:0] weight_a;
  logic signed [23:0] weight_b;
  logic signed [23:0] weight_c;
  logic signed [23:0] weight_d;
  logic signed [23:0] weight_e;
  logic signed [23:0] weight_f;
  logic               order_error;
  modport source (output valid, output start_index, output weight_a, output weight_b,
                  output weight_c, output weight_d, output weight_e, output weight_f,
                  output order_error, input ready);
  modport sink   (input valid, input start_index, input weight_a, input weight_b,
                  input weight_c, input weight_d, input weight_e, input weight_f,
                  input order_error, output ready);
endinterface

interface swg_cfg_if;
  logic       valid;
  logic       ready;
  logic [1:0] index;
  logic [2:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// File: rtl/spline_interp_weight_generator.sv
// Channel | Dir | Payload
// pos_i   | in  | position (signed Q16.16)
// res_o   | out | start_index, weight_a..weight_f (Q7.16), order_error
// cfg_i   | in  | index (0 kernel_kind, 1 derivative_order), data
//
// Pipeline: front stage, five Horner steps of two stages each (multiply,
// add), four scaling stages. One position per cycle sustained while the
// output is not stalled. rst_ni is asynchronous: clears valid bits,
// kernel_kind to B-spline 3, derivative_order to 0. Each stage advances
// when its successor is free, so bubbles close up under a stalled output;
// ready drops only when all fifteen stages hold an item.
`default_nettype none
`include "spline_interp_weight_generator_defines.svh"

module spline_interp_weight_generator (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  swg_pos_if.sink     pos_i,
  swg_res_if.source   res_o,
  swg_cfg_if.sink     cfg_i
);

  localparam int NSTEP = 5;

  logic [2:0] kind_q;
  logic [2:0] order_q;

  // Config registers; writes to unused indexes are dropped.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kind_q  <= swg_pkg::KIND_RESET;
      order_q <= swg_pkg::ORDER_RESET;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        swg_pkg::REG_KIND:  kind_q  <= cfg_i.data;
        swg_pkg::REG_ORDER: order_q <= cfg_i.data;
        default: ;
      endcase
    end
  end

  assign cfg_i.ready = 1'b1;

  // Pipeline link signals: index 0 is the front stage output.
  logic               lv [NSTEP+1];
  logic               lr [NSTEP+1];
  swg_pkg::swg_item_t li [NSTEP+1];

  swg_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (pos_i.valid),
    .in_ready_o  (pos_i.ready),
    .position_i  (pos_i.position),
    .kind_i      (kind_q),
    .order_i     (order_q),
    .out_valid_o (lv[0]),
    .out_item_o  (li[0]),
    .out_ready_i (lr[0])
  );

  // Horner steps for x^4 down to x^0; the front seeds the x^5 term.
  for (genvar g = 0; g < NSTEP; g++) begin : g_step
    swg_horner_step u_step (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .k_i         (3'(NSTEP - 1 - g)),
      .in_valid_i  (lv[g]),
      .in_ready_o  (lr[g]),
      .in_item_i   (li[g]),
      .out_valid_o (lv[g+1]),
      .out_item_o  (li[g+1]),
      .out_ready_i (lr[g+1])
    );
  end

  swg_pkg::swg_res_t res;

  swg_scale u_scale (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (lv[NSTEP]),
    .in_ready_o  (lr[NSTEP]),
    .in_item_i   (li[NSTEP]),
    .out_valid_o (res_o.valid),
    .out_res_o   (res),
    .out_ready_i (res_o.ready)
  );

  assign res_o.start_index = res.start;
  assign res_o.weight_a    = res.w[0];
  assign res_o.weight_b    = res.w[1];
  assign res_o.weight_c    = res.w[2];
  assign res_o.weight_d    = res.w[3];
  assign res_o.weight_e    = res.w[4];
  assign res_o.weight_f    = res.w[5];
  assign res_o.order_error = res.err;

  // An error result carries no weights.
  `SWG_ASSERT_IMP(a_err_low_zero,
    res_o.valid && res_o.order_error,
    res_o.weight_a == 24'd0 && res_o.weight_b == 24'd0 && res_o.weight_c == 24'd0,
    "order error with nonzero low weights")
  `SWG_ASSERT_IMP(a_err_high_zero,
    res_o.valid && res_o.order_error,
    res_o.weight_d == 24'd0 && res_o.weight_e == 24'd0 && res_o.weight_f == 24'd0,
    "order error with nonzero high weights")
  // Input back-pressure only comes from a stalled output.
  `SWG_ASSERT_IMP(a_ready_low_stalled,
    !pos_i.ready,
    res_o.valid && !res_o.ready,
    "input stalled while output free")
  `SWG_ASSERT_NXT(a_kind_write,
    cfg_i.valid && cfg_i.index == swg_pkg::REG_KIND,
    kind_q == $past(cfg_i.data),
    "kernel kind write lost")

endmodule

`default_nettype wire

// File: rtl/swg_front.sv
`default_nettype none

// Index/fraction split, row selection and Horner seed.
module swg_front (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  output logic                      in_ready_o,
  input  wire logic signed [31:0]   position_i,
  input  wire logic [2:0]           kind_i,
  input  wire logic [2:0]           order_i,
  output logic                      out_valid_o,
  output swg_pkg::swg_item_t        out_item_o,
  input  wire logic                 out_ready_i
);

  swg_pkg::swg_kinfo_t ki;
  logic [32:0]         sum;
  logic                err;
  logic                go;
  logic [6:0]          row [swg_pkg::LANES];
  swg_pkg::swg_item_t  item_d, item_q;
  logic                valid_q;
  logic                en;

  always_comb begin
    ki  = swg_pkg::kinfo(kind_i);
    sum = {position_i[31], position_i} + {17'd0, ki.shifted, 15'd0};
    err = (kind_i == swg_pkg::K_HAAR) && (order_i != 3'd0);
    go  = ki.ok && !err && (order_i <= {1'b0, ki.max_order});
    item_d        = '0;
    item_d.start  = sum[32:16] - {15'd0, ki.half};
    item_d.err    = err;
    item_d.dcode  = ki.dcode;
    item_d.dshift = ki.dshift;
    item_d.u      = {1'b0, sum[15:0]} - {1'b0, ki.shifted, 15'd0};
    for (int j = 0; j < swg_pkg::LANES; j++) begin
      row[j] = ki.base + 7'(order_i) * 7'(ki.support) + 7'(j);
      item_d.mask[j] = go && (3'(j) < ki.support);
      item_d.rows[j] = item_d.mask[j] ? row[j] : 7'd0;
      item_d.acc[j]  = swg_pkg::coef_q32(swg_pkg::coef(item_d.rows[j], 3'd5));
    end
  end

  assign en = !valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en && in_valid_i) begin
      item_q <= item_d;
    end
  end

  assign in_ready_o  = en;
  assign out_valid_o = valid_q;
  assign out_item_o  = item_q;

endmodule

`default_nettype wire

// File: rtl/swg_horner_step.sv
`default_nettype none

// One Horner step: acc = round(acc * u / 2^16) + c_k * 2^32, all lanes.
// Multiply stage splits acc into two partial products; add stage merges.
module swg_horner_step (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic [2:0]           k_i,
  input  wire logic                 in_valid_i,
  output logic                      in_ready_o,
  input  wire swg_pkg::swg_item_t   in_item_i,
  output logic                      out_valid_o,
  output swg_pkg::swg_item_t        out_item_o,
  input  wire logic                 out_ready_i
);

  logic signed [22:0] ah [swg_pkg::LANES];
  logic signed [23:0] al [swg_pkg::LANES];
  logic signed [39:0] ph_d [swg_pkg::LANES];
  logic signed [40:0] pl_d [swg_pkg::LANES];
  logic signed [39:0] ph_q [swg_pkg::LANES];
  logic signed [40:0] pl_q [swg_pkg::LANES];
  logic [63:0]        psum [swg_pkg::LANES];
  swg_pkg::swg_item_t mul_q, add_d, add_q;
  logic               vm_q, va_q;
  logic               en_m, en_a;

  always_comb begin
    for (int j = 0; j < swg_pkg::LANES; j++) begin
      ah[j]   = in_item_i.acc[j][45:23];
      al[j]   = {1'b0, in_item_i.acc[j][22:0]};
      ph_d[j] = ah[j] * in_item_i.u;
      pl_d[j] = al[j] * in_item_i.u;
    end
  end

  always_comb begin
    add_d = mul_q;
    for (int j = 0; j < swg_pkg::LANES; j++) begin
      psum[j] = ({{24{ph_q[j][39]}}, ph_q[j]} << 23) + {{23{pl_q[j][40]}}, pl_q[j]}
                + 64'd32768;
      add_d.acc[j] = psum[j][61:16]
                     + swg_pkg::coef_q32(swg_pkg::coef(mul_q.rows[j], k_i));
    end
  end

  assign en_a = !va_q || out_ready_i;
  assign en_m = !vm_q || en_a;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vm_q <= 1'b0;
      va_q <= 1'b0;
    end else begin
      if (en_m) begin
        vm_q <= in_valid_i;
      end
      if (en_a) begin
        va_q <= vm_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_m && in_valid_i) begin
      mul_q <= in_item_i;
      ph_q  <= ph_d;
      pl_q  <= pl_d;
    end
    if (en_a && vm_q) begin
      add_q <= add_d;
    end
  end

  assign in_ready_o  = en_m;
  assign out_valid_o = va_q;
  assign out_item_o  = add_q;

endmodule

`default_nettype wire

// File: rtl/swg_scale.sv
`default_nettype none

// Final scaling: w = floor((acc + D*2^15) / (D*2^16)), saturated, masked.
// D = b * 2^a; the 2^a part is a shift, the odd part b a reciprocal
// multiply with one correction step.
module swg_scale (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  output logic                      in_ready_o,
  input  wire swg_pkg::swg_item_t   in_item_i,
  output logic                      out_valid_o,
  output swg_pkg::swg_res_t         out_res_o,
  input  wire logic                 out_ready_i
);

  localparam int NST = 4;

  typedef struct packed {
    logic signed [16:0]              start;
    logic                            err;
    swg_pkg::swg_div_e               dcode;
    logic [swg_pkg::LANES-1:0]       mask;
  } sc_side_t;

  logic [NST-1:0] v_q;
  logic [NST-1:0] en;
  sc_side_t       s1_q, s2_q, s3_q;

  // stage 1
  logic [4:0]         b1;
  logic [8:0]         dval;
  logic [45:0]        t [swg_pkg::LANES];
  logic signed [29:0] n2 [swg_pkg::LANES];
  logic [29:0]        m_d [swg_pkg::LANES];
  logic [29:0]        m1_q [swg_pkg::LANES];
  logic [swg_pkg::LANES-1:0] neg_d, neg1_q, neg2_q, neg3_q;

  // stage 2
  logic [61:0] prod [swg_pkg::LANES];
  logic [29:0] q0_d [swg_pkg::LANES];
  logic [29:0] q2_q [swg_pkg::LANES];
  logic [29:0] m2_q [swg_pkg::LANES];

  // stage 3
  logic [4:0]  b3;
  logic [29:0] rem [swg_pkg::LANES];
  logic [29:0] q_d [swg_pkg::LANES];
  logic [29:0] q3_q [swg_pkg::LANES];

  // stage 4
  logic signed [30:0] ws [swg_pkg::LANES];
  swg_pkg::swg_res_t  res_d, res_q;

  always_comb begin
    b1   = swg_pkg::div_b(in_item_i.dcode);
    dval = {4'd0, b1} << in_item_i.dshift;
    for (int j = 0; j < swg_pkg::LANES; j++) begin
      t[j]     = in_item_i.acc[j] + {22'd0, dval, 15'd0};
      n2[j]    = $signed(t[j][45:16]) >>> in_item_i.dshift;
      neg_d[j] = n2[j][29];
      m_d[j]   = neg_d[j] ? (30'd0 - 30'(n2[j]) + {25'd0, b1} - 30'd1) : 30'(n2[j]);
    end
  end

  always_comb begin
    for (int j = 0; j < swg_pkg::LANES; j++) begin
      prod[j] = 62'(m1_q[j]) * 62'(swg_pkg::div_r(s1_q.dcode));
      q0_d[j] = (s1_q.dcode == swg_pkg::DIV_1) ? m1_q[j] : prod[j][61:32];
    end
  end

  always_comb begin
    b3 = swg_pkg::div_b(s2_q.dcode);
    for (int j = 0; j < swg_pkg::LANES; j++) begin
      rem[j] = m2_q[j] - q2_q[j] * 30'(b3);
      q_d[j] = q2_q[j] + {29'd0, (rem[j] >= 30'(b3))};
    end
  end

  always_comb begin
    res_d       = '0;
    res_d.start = s3_q.start;
    res_d.err   = s3_q.err;
    for (int j = 0; j < swg_pkg::LANES; j++) begin
      ws[j] = neg3_q[j] ? (31'sd0 - $signed({1'b0, q3_q[j]})) : $signed({1'b0, q3_q[j]});
      if (!s3_q.mask[j]) begin
        res_d.w[j] = 24'd0;
      end else if (ws[j] > 31'sd8388607) begin
        res_d.w[j] = 24'h7FFFFF;
      end else if (ws[j] < -31'sd8388608) begin
        res_d.w[j] = 24'h800000;
      end else begin
        res_d.w[j] = ws[j][23:0];
      end
    end
  end

  always_comb begin
    en[NST-1] = !v_q[NST-1] || out_ready_i;
    for (int s = NST - 2; s >= 0; s--) begin
      en[s] = !v_q[s] || en[s+1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (en[0]) v_q[0] <= in_valid_i;
      for (int s = 1; s < NST; s++) begin
        if (en[s]) v_q[s] <= v_q[s-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[0] && in_valid_i) begin
      s1_q   <= '{in_item_i.start, in_item_i.err, in_item_i.dcode, in_item_i.mask};
      m1_q   <= m_d;
      neg1_q <= neg_d;
    end
    if (en[1] && v_q[0]) begin
      s2_q   <= s1_q;
      q2_q   <= q0_d;
      m2_q   <= m1_q;
      neg2_q <= neg1_q;
    end
    if (en[2] && v_q[1]) begin
      s3_q   <= s2_q;
      q3_q   <= q_d;
      neg3_q <= neg2_q;
    end
    if (en[3] && v_q[2]) begin
      res_q <= res_d;
    end
  end

  assign in_ready_o  = en[0];
  assign out_valid_o = v_q[NST-1];
  assign out_res_o   = res_q;

endmodule

`default_nettype wire

// File: tb/testbench.sv
// Weight generator check: positions go in through the position channel, the
// scoreboard predicts start index and six Q7.16 weights for the current
// kernel and derivative order, and every result transfer is compared field
// by field. Registers are rewritten between phases while the pipeline is
// empty.
module testbench;

  localparam int WATCHDOG = 20000;
  localparam int DRAIN = 40;

  typedef struct packed {
    logic signed [16:0] start_index;
    logic signed [23:0] wa, wb, wc, wd, we, wf;
    logic               order_error;
  } weights_t;

  // Kernel tables mirrored as plain ints (shift, half degree, support,
  // highest order, denominator, first polynomial row).
  class weight_scoreboard;
    weights_t pending[$];
    logic [2:0] kind;
    logic [2:0] order;
    int errors;

    function new();
      kind = swg_pkg::KIND_RESET;
      order = swg_pkg::ORDER_RESET;
      errors = 0;
    endfunction

    // floor(n/d), d > 0
    function longint fdiv(longint n, longint d);
      longint q;
      q = n / d;
      if ((n % d) != 0 && n < 0) q = q - 1;
      return q;
    endfunction

    function longint horner(int row, longint u, longint den);
      longint acc, w;
      acc = longint'(swg_pkg::POLY[row][5]) * 64'sd4294967296;
      for (int k = 4; k >= 0; k--)
        acc = fdiv(acc * u + 32768, 65536)
              + longint'(swg_pkg::POLY[row][k]) * 64'sd4294967296;
      w = fdiv(acc + den * 32768, den * 65536);
      if (w > 8388607) w = 8388607;
      if (w < -8388608) w = -8388608;
      return w;
    endfunction

    function void note_position(logic signed [31:0] pos);
      longint sh, hf, den, ix, u;
      int sup, maxo, base;
      longint w[6];
      weights_t r;
      sh = 0; hf = 0; sup = 0; maxo = -1; den = 1; base = 0;
      case (kind)
        swg_pkg::K_HAAR:     begin sh = 32768; hf = 0; sup = 1; maxo = 0; den = 1;   base = 0;  end
        swg_pkg::K_BSPLINE2: begin sh = 32768; hf = 1; sup = 3; maxo = 2; den = 8;   base = 1;  end
        swg_pkg::K_BSPLINE3: begin sh = 0;     hf = 1; sup = 4; maxo = 3; den = 6;   base = 10; end
        swg_pkg::K_OMOMS3:   begin sh = 0;     hf = 1; sup = 4; maxo = 2; den = 42;  base = 26; end
        swg_pkg::K_BSPLINE4: begin sh = 32768; hf = 2; sup = 5; maxo = 3; den = 384; base = 38; end
        swg_pkg::K_BSPLINE5: begin sh = 0;     hf = 2; sup = 6; maxo = 3; den = 120; base = 58; end
        default: ;
      endcase
      ix = fdiv(longint'(pos) + sh, 65536);
      u = longint'(pos) - ix * 65536;
      foreach (w[j]) w[j] = 0;
      r.order_error = (kind == swg_pkg::K_HAAR) && (order != 0);
      if (!r.order_error && int'(order) <= maxo)
        for (int j = 0; j < sup; j++) w[j] = horner(base + int'(order) * sup + j, u, den);
      r.start_index = 17'(ix - hf);
      r.wa = 24'(w[0]); r.wb = 24'(w[1]); r.wc = 24'(w[2]);
      r.wd = 24'(w[3]); r.we = 24'(w[4]); r.wf = 24'(w[5]);
      pending = {pending, r};
    endfunction

    function void check_result(weights_t got);
      weights_t exp;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result %h", $time, got);
        errors++;
        return;
      end
      exp = pending.pop_front();
      if (got.start_index !== exp.start_index) begin
        $display("%0t: start_index exp %0d got %0d", $time, exp.start_index, got.start_index);
        errors++;
      end
      if (got.wa !== exp.wa) begin
        $display("%0t: weight_a exp %0d got %0d", $time, exp.wa, got.wa); errors++;
      end
      if (got.wb !== exp.wb) begin
        $display("%0t: weight_b exp %0d got %0d", $time, exp.wb, got.wb); errors++;
      end
      if (got.wc !== exp.wc) begin
        $display("%0t: weight_c exp %0d got %0d", $time, exp.wc, got.wc); errors++;
      end
      if (got.wd !== exp.wd) begin
        $display("%0t: weight_d exp %0d got %0d", $time, exp.wd, got.wd); errors++;
      end
      if (got.we !== exp.we) begin
        $display("%0t: weight_e exp %0d got %0d", $time, exp.we, got.we); errors++;
      end
      if (got.wf !== exp.wf) begin
        $display("%0t: weight_f exp %0d got %0d", $time, exp.wf, got.wf); errors++;
      end
      if (got.order_error !== exp.order_error) begin
        $display("%0t: order_error exp %0b got %0b", $time, exp.order_error, got.order_error);
        errors++;
      end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  always #5 clk_i = ~clk_i;

  swg_pos_if pos_if();
  swg_res_if res_if();
  swg_cfg_if cfg_if();

  spline_interp_weight_generator dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .pos_i  (pos_if.sink),
    .res_o  (res_if.source),
    .cfg_i  (cfg_if.sink)
  );

  weight_scoreboard sb = new();
  int send_idle_pct = 0;   // chance per cycle that the sender holds off
  int stall_pct = 0;       // chance per cycle that the receiver stalls
  int idle_cycles = 0;
  bit timed_out = 1'b0;

  initial begin
    pos_if.valid = 1'b0;
    pos_if.position = '0;
    cfg_if.valid = 1'b0;
    cfg_if.index = '0;
    cfg_if.data = '0;
    res_if.ready = 1'b0;
  end

  // Receiver: ready toggles randomly per the current stall rate.
  always @(posedge clk_i) begin
    res_if.ready <= ($urandom_range(99) >= stall_pct);
  end

  // Monitor: input transfers feed the predictor, result transfers the checker.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (pos_if.valid && pos_if.ready) sb.note_position(pos_if.position);
      if (res_if.valid && res_if.ready)
        sb.check_result({res_if.start_index, res_if.weight_a, res_if.weight_b,
                         res_if.weight_c, res_if.weight_d, res_if.weight_e,
                         res_if.weight_f, res_if.order_error});
      if ((pos_if.valid && pos_if.ready) || (res_if.valid && res_if.ready) ||
          (cfg_if.valid && cfg_if.ready))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
    end
  end

  // Watchdog: ends the run as failed once the idle count reaches WATCHDOG.
  always @(posedge clk_i) begin
    if (idle_cycles >= WATCHDOG && !timed_out) begin
      timed_out = 1'b1;
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // valid stays high after a transfer so back-to-back items need no gap;
  // it drops on an idle cycle or when the stream ends in drain().
  task automatic send_position(logic signed [31:0] p);
    while ($urandom_range(99) < send_idle_pct) begin
      pos_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    pos_if.valid <= 1'b1;
    pos_if.position <= p;
    @(posedge clk_i);
    while (!pos_if.ready) @(posedge clk_i);
  endtask

  // Only called with the pipeline drained; the register changes the
  // predictor's view at the same transfer edge.
  task automatic write_reg(logic [1:0] idx, logic [2:0] val);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data <= val;
    @(posedge clk_i);
    while (!cfg_if.ready) @(posedge clk_i);
    if (idx == swg_pkg::REG_KIND) sb.kind = val;
    else sb.order = val;
    cfg_if.valid <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic drain();
    pos_if.valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (DRAIN) @(posedge clk_i);
  endtask

  // Small positions, sometimes the full range, fractions next to the integer grid,
  // and fractions hitting the half-point where shifted kernels change index.
  function automatic logic signed [31:0] rand_position();
    logic [31:0] p;
    case ($urandom_range(5))
      0: p = $urandom();
      1: p = {16'($urandom_range(65535)), 16'h8000};
      2: p = {16'($urandom_range(65535)), 16'h7fff + 16'($urandom_range(2))};
      3: p = {16'($urandom_range(65535)), ($urandom_range(1) ? 16'h0000 : 16'hffff)};
      default: p = 32'($signed($urandom_range(2000000)) - 1000000);
    endcase
    return p;
  endfunction

  initial begin
    logic signed [31:0] corners[$];
    int phase;
    corners = '{32'h8000_0000, 32'h7fff_ffff, 32'h0, 32'hffff_ffff, 32'h0000_8000,
                32'hffff_8000, 32'h0000_7fff, 32'h0001_0000, 32'h7fff_8000,
                32'h8000_8000, 32'h5555_5555, 32'haaaa_aaaa};
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // Directed: corner positions under reset setting, then every kernel code,
    // the undefined ones included, at derivative orders 0, 3 and 6, which gives
    // Haar with a nonzero order.
    foreach (corners[i]) send_position(corners[i]);
    drain();
    for (int k = 0; k < 8; k++) begin
      write_reg(swg_pkg::REG_KIND, 3'(k));
      for (int o = 0; o < 8; o += 3) begin
        write_reg(swg_pkg::REG_ORDER, 3'(o));
        send_position(corners[$urandom_range(corners.size() - 1)]);
        send_position(rand_position());
        drain();
      end
    end

    // Random phases, each with fresh register settings and idling profile.
    for (phase = 0; phase < 32; phase++) begin
      case (phase % 4)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 82; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 82; end
        default: begin send_idle_pct = 36; stall_pct = 36; end
      endcase
      write_reg(swg_pkg::REG_KIND, ($urandom_range(9) == 0) ? 3'($urandom_range(7, 6))
                                                            : 3'($urandom_range(5)));
      write_reg(swg_pkg::REG_ORDER, ($urandom_range(4) == 0) ? 3'($urandom_range(7))
                                                             : 3'($urandom_range(3)));
      repeat (50) send_position(rand_position());
      drain();
    end

    send_idle_pct = 0;
    stall_pct = 0;
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end
endmodule
